// ----- hdl/multichannel_sample_collector_assert.svh -----
// ---------------------------------------------------------------------------
// Sample collector assertion macros
// Short forms for the concurrent checks of the collector.
// ---------------------------------------------------------------------------
`ifndef MULTICHANNEL_SAMPLE_COLLECTOR_ASSERT_SVH
`define MULTICHANNEL_SAMPLE_COLLECTOR_ASSERT_SVH

// same-cycle implication, disabled while reset is high
`define MSC_ASSERT_IMPL(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication, disabled while reset is high
`define MSC_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ----- hdl/msc_pkg.sv -----
// ---------------------------------------------------------------------------
// Sample collector package
// Shared constants, codes and transaction types of the collector.
// ---------------------------------------------------------------------------
package msc_pkg;

   localparam int NUM_CHANNELS = 4;
   localparam int SAMPLE_BITS  = 10;

   localparam int CHAN_W   = 2;
   localparam int SAMPLE_W = 10;
   localparam int INDEX_W  = 16;
   localparam int CSR_W    = 16;
   localparam int CSR_IDX_W = 2;

   localparam logic [3:0] CHAN_ALL = 4'((1 << NUM_CHANNELS) - 1);
   localparam logic [SAMPLE_W-1:0] SAMPLE_MASK = SAMPLE_W'((1 << SAMPLE_BITS) - 1);
   localparam logic [SAMPLE_W-1:0] LOW_RES_MASK = SAMPLE_W'(8'hFF);

   localparam int QUEUE_DEPTH = 2;
   localparam int PTR_W = 1;
   localparam int CNT_W = 2;

   // request codes
   localparam logic REQ_START  = 1'b0;
   localparam logic REQ_STATUS = 1'b1;

   // result kinds
   typedef enum logic [1:0] {
      KIND_START      = 2'd0,
      KIND_STORED     = 2'd1,
      KIND_DROPPED    = 2'd2,
      KIND_UNEXPECTED = 2'd3
   } kind_type;

   // configuration register indexes
   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_SAMPLE_COUNT = 2'd0,
      CSR_LOW_RES      = 2'd1,
      CSR_SW_TRIGGER   = 2'd2,
      CSR_CH_ENABLE    = 2'd3
   } csr_idx_type;

   // one queued job: a set of channels to report plus the end-of-item flags
   typedef struct packed {
      logic [3:0]                               flags;
      kind_type [3:0]                           kinds;
      logic [3:0][SAMPLE_W-1:0]                 values;
      logic [INDEX_W-1:0]                       index;
      logic                                     round_complete;
      logic                                     acq_done;
      logic                                     start_conv;
   } job_type;

   typedef struct packed {
      logic    valid;
      job_type job;
   } head_type;

endpackage

// ----- hdl/msc_front.sv -----
// ---------------------------------------------------------------------------
// Sample collector front end
// Holds configuration and arming state, classifies each request transaction
// and turns starts and armed status requests with a flag set into jobs for the back end.
// ---------------------------------------------------------------------------
module msc_front (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          csr_valid,
   output logic                          csr_ready,
   input  logic [msc_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [msc_pkg::CSR_W-1:0]     csr_data,
   input  logic                          req_valid,
   output logic                          req_ready,
   input  logic                          req_type,
   input  logic [3:0]                    req_eoc_bits,
   input  logic [msc_pkg::SAMPLE_W-1:0]  req_sample_ch0,
   input  logic [msc_pkg::SAMPLE_W-1:0]  req_sample_ch1,
   input  logic [msc_pkg::SAMPLE_W-1:0]  req_sample_ch2,
   input  logic [msc_pkg::SAMPLE_W-1:0]  req_sample_ch3,
   input  logic [3:0]                    req_buffer_present,
   input  logic                          queue_full,
   output logic                          push,
   output msc_pkg::job_type              push_job
);

   logic [msc_pkg::INDEX_W-1:0] sample_count_ff;
   logic                        low_res_ff;
   logic                        sw_trigger_ff;
   logic [3:0]                  ch_enable_ff;

   logic                        armed_ff, armed_in;
   logic [3:0]                  pending_ff, pending_in;
   logic [msc_pkg::INDEX_W-1:0] round_ff, round_in;

   logic [3:0][msc_pkg::SAMPLE_W-1:0] samples;
   logic [3:0]                  eoc;
   logic [3:0]                  pend_left;
   logic [msc_pkg::INDEX_W-1:0] round_next;
   logic                        round_done;
   logic                        count_hit;
   logic                        accept;
   logic                        is_start;
   logic                        status_go;
   logic [msc_pkg::SAMPLE_W-1:0] res_mask;

   assign csr_ready = 1'b1;
   assign req_ready = !queue_full;
   assign accept    = req_valid && req_ready;

   assign samples[0] = req_sample_ch0;
   assign samples[1] = req_sample_ch1;
   assign samples[2] = req_sample_ch2;
   assign samples[3] = req_sample_ch3;

   assign eoc        = req_eoc_bits & msc_pkg::CHAN_ALL;
   assign is_start   = (req_type == msc_pkg::REQ_START);
   assign status_go  = !is_start && armed_ff && (eoc != 4'd0);
   assign pend_left  = pending_ff & ~eoc;
   assign round_done = (pend_left == 4'd0);
   assign round_next = round_ff + 1'b1;
   assign count_hit  = (round_next == sample_count_ff);
   assign res_mask   = low_res_ff ? (msc_pkg::SAMPLE_MASK & msc_pkg::LOW_RES_MASK)
                                  : msc_pkg::SAMPLE_MASK;

   assign push = accept && (is_start || status_go);

   // job build
   always_comb begin
      push_job = '0;
      if (is_start) begin
         push_job.flags      = 4'b0001;
         for (int i = 0; i < 4; i++) begin
            push_job.kinds[i] = msc_pkg::KIND_START;
         end
         push_job.start_conv = sw_trigger_ff;
      end else begin
         push_job.flags = eoc;
         push_job.index = round_ff;
         for (int i = 0; i < 4; i++) begin
            if (pending_ff[i]) begin
               push_job.kinds[i]  = req_buffer_present[i] ? msc_pkg::KIND_STORED
                                                          : msc_pkg::KIND_DROPPED;
               push_job.values[i] = samples[i] & res_mask;
            end else begin
               push_job.kinds[i]  = msc_pkg::KIND_UNEXPECTED;
               push_job.values[i] = '0;
            end
         end
         push_job.round_complete = round_done;
         push_job.acq_done       = round_done && count_hit;
         push_job.start_conv     = round_done && !count_hit && sw_trigger_ff;
      end
   end

   // arming state update
   always_comb begin
      armed_in   = armed_ff;
      pending_in = pending_ff;
      round_in   = round_ff;
      if (accept && is_start) begin
         armed_in   = 1'b1;
         pending_in = ch_enable_ff & msc_pkg::CHAN_ALL;
         round_in   = '0;
      end else if (accept && status_go) begin
         if (round_done) begin
            pending_in = ch_enable_ff & msc_pkg::CHAN_ALL;
            round_in   = round_next;
            armed_in   = !count_hit;
         end else begin
            pending_in = pend_left;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         armed_ff   <= 1'b0;
         pending_ff <= '0;
         round_ff   <= '0;
      end else begin
         armed_ff   <= armed_in;
         pending_ff <= pending_in;
         round_ff   <= round_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sample_count_ff <= msc_pkg::INDEX_W'(1);
         low_res_ff      <= 1'b0;
         sw_trigger_ff   <= 1'b1;
         ch_enable_ff    <= 4'hF;
      end else if (csr_valid && csr_ready) begin
         unique case (msc_pkg::csr_idx_type'(csr_index))
            msc_pkg::CSR_SAMPLE_COUNT: sample_count_ff <= csr_data;
            msc_pkg::CSR_LOW_RES:      low_res_ff      <= csr_data[0];
            msc_pkg::CSR_SW_TRIGGER:   sw_trigger_ff   <= csr_data[0];
            msc_pkg::CSR_CH_ENABLE:    ch_enable_ff    <= csr_data[3:0];
         endcase
      end
   end

endmodule

// ----- hdl/msc_queue.sv -----
// ---------------------------------------------------------------------------
// Sample collector job queue
// Two-entry FIFO of jobs between front and back end.
// ---------------------------------------------------------------------------
module msc_queue (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   input  msc_pkg::job_type  push_job,
   output logic              full,
   input  logic              pop,
   output msc_pkg::head_type head
);

   msc_pkg::job_type               slots_ff [msc_pkg::QUEUE_DEPTH];
   logic [msc_pkg::PTR_W-1:0]      wr_ptr_ff, wr_ptr_in;
   logic [msc_pkg::PTR_W-1:0]      rd_ptr_ff, rd_ptr_in;
   logic [msc_pkg::CNT_W-1:0]      count_ff, count_in;

   assign full       = (count_ff == msc_pkg::CNT_W'(msc_pkg::QUEUE_DEPTH));
   assign head.valid = (count_ff != '0);
   assign head.job   = slots_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = pop  ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slots_ff[wr_ptr_ff] <= push_job;
      end
   end

endmodule

// ----- hdl/msc_back.sv -----
// ---------------------------------------------------------------------------
// Sample collector back end
// Walks the flagged channels of the head job, lowest first, and emits one
// response transaction per cycle through an output register while rsp_ready allows.
// ---------------------------------------------------------------------------
module msc_back (
   input  logic                         clock,
   input  logic                         reset,
   input  msc_pkg::head_type            head,
   output logic                         pop,
   output logic                         rsp_valid,
   input  logic                         rsp_ready,
   output logic [1:0]                   rsp_result_kind,
   output logic [msc_pkg::CHAN_W-1:0]   rsp_channel,
   output logic [msc_pkg::SAMPLE_W-1:0] rsp_sample_value,
   output logic [msc_pkg::INDEX_W-1:0]  rsp_sample_index,
   output logic                         rsp_last,
   output logic                         rsp_round_complete,
   output logic                         rsp_acquisition_done,
   output logic                         rsp_start_conversion
);

   logic [3:0]                   used_ff, used_in;
   logic                         rsp_valid_ff, rsp_valid_in;
   logic [1:0]                   kind_ff;
   logic [msc_pkg::CHAN_W-1:0]   chan_ff;
   logic [msc_pkg::SAMPLE_W-1:0] value_ff;
   logic [msc_pkg::INDEX_W-1:0]  index_ff;
   logic                         last_ff, rcomp_ff, done_ff, start_ff;

   logic [3:0]                   remain;
   logic [3:0]                   sel_bit;
   logic [msc_pkg::CHAN_W-1:0]   sel_idx;
   logic                         slot_free;
   logic                         emit;
   logic                         is_last;

   assign remain    = head.job.flags & ~used_ff;
   assign slot_free = !rsp_valid_ff || rsp_ready;
   assign emit      = head.valid && slot_free;
   assign is_last   = ((remain & ~sel_bit) == 4'd0);
   assign pop       = emit && is_last;

   // lowest remaining channel
   always_comb begin
      sel_idx = '0;
      sel_bit = '0;
      for (int i = 3; i >= 0; i--) begin
         if (remain[i]) begin
            sel_idx = msc_pkg::CHAN_W'(i);
            sel_bit = 4'(1 << i);
         end
      end
   end

   always_comb begin
      used_in = used_ff;
      if (pop) begin
         used_in = '0;
      end else if (emit) begin
         used_in = used_ff | sel_bit;
      end
      rsp_valid_in = rsp_valid_ff;
      if (emit) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         used_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         used_ff      <= used_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (emit) begin
         kind_ff  <= head.job.kinds[sel_idx];
         chan_ff  <= sel_idx;
         value_ff <= head.job.values[sel_idx];
         index_ff <= head.job.index;
         last_ff  <= is_last;
         rcomp_ff <= is_last && head.job.round_complete;
         done_ff  <= is_last && head.job.acq_done;
         start_ff <= is_last && head.job.start_conv;
      end
   end

   assign rsp_valid            = rsp_valid_ff;
   assign rsp_result_kind      = kind_ff;
   assign rsp_channel          = chan_ff;
   assign rsp_sample_value     = value_ff;
   assign rsp_sample_index     = index_ff;
   assign rsp_last             = last_ff;
   assign rsp_round_complete   = rcomp_ff;
   assign rsp_acquisition_done = done_ff;
   assign rsp_start_conversion = start_ff;

endmodule

// ----- hdl/multichannel_sample_collector.sv -----
// A taken request is queued as a job; its responses reach rsp_* via the output register.
// Throughput: one request per cycle at the front while the two-entry job queue has room;
// the back end sends one response per cycle while rsp_ready allows, so a request with n
// flagged channels (1 to 4) gives n responses, a start request one.
// Reset (synchronous, active high): disarmed, pending mask and round counter zero,
// registers at their defaults, job queue and output register empty.
// ---------------------------------------------------------------------------
// Multichannel sample collector
// Arms on a start transaction, collects per-channel samples from status
// transactions and reports each one as stored, dropped or unexpected.
// ---------------------------------------------------------------------------
module multichannel_sample_collector (
   input  logic                          clock,
   input  logic                          reset,
   // configuration write channel
   input  logic                          csr_valid,
   output logic                          csr_ready,
   input  logic [msc_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [msc_pkg::CSR_W-1:0]     csr_data,
   // request channel
   input  logic                          req_valid,
   output logic                          req_ready,
   input  logic                          req_type,
   input  logic [3:0]                    req_eoc_bits,
   input  logic [msc_pkg::SAMPLE_W-1:0]  req_sample_ch0,
   input  logic [msc_pkg::SAMPLE_W-1:0]  req_sample_ch1,
   input  logic [msc_pkg::SAMPLE_W-1:0]  req_sample_ch2,
   input  logic [msc_pkg::SAMPLE_W-1:0]  req_sample_ch3,
   input  logic [3:0]                    req_buffer_present,
   // response channel
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic [1:0]                    rsp_result_kind,
   output logic [msc_pkg::CHAN_W-1:0]    rsp_channel,
   output logic [msc_pkg::SAMPLE_W-1:0]  rsp_sample_value,
   output logic [msc_pkg::INDEX_W-1:0]   rsp_sample_index,
   output logic                          rsp_last,
   output logic                          rsp_round_complete,
   output logic                          rsp_acquisition_done,
   output logic                          rsp_start_conversion
);

   // front -> queue
   logic              push;
   msc_pkg::job_type  push_job;
   logic              queue_full;
   // queue -> back
   msc_pkg::head_type head;
   logic              pop;

   // Front end: all arming state lives here and is updated the cycle a
   // request is taken, so the next request sees it right away. Status
   // transactions while disarmed, or with no flag on an existing channel,
   // are absorbed without a job.
   msc_front u_front (
      .clock              (clock),
      .reset              (reset),
      .csr_valid          (csr_valid),
      .csr_ready          (csr_ready),
      .csr_index          (csr_index),
      .csr_data           (csr_data),
      .req_valid          (req_valid),
      .req_ready          (req_ready),
      .req_type           (req_type),
      .req_eoc_bits       (req_eoc_bits),
      .req_sample_ch0     (req_sample_ch0),
      .req_sample_ch1     (req_sample_ch1),
      .req_sample_ch2     (req_sample_ch2),
      .req_sample_ch3     (req_sample_ch3),
      .req_buffer_present (req_buffer_present),
      .queue_full         (queue_full),
      .push               (push),
      .push_job           (push_job)
   );

   // Job queue: decouples request acceptance from response backpressure.
   msc_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .push_job (push_job),
      .full     (queue_full),
      .pop      (pop),
      .head     (head)
   );

   // Back end: one response per cycle while rsp_ready allows; the end-of-item
   // flags ride on the last response of each job only.
   msc_back u_back (
      .clock                (clock),
      .reset                (reset),
      .head                 (head),
      .pop                  (pop),
      .rsp_valid            (rsp_valid),
      .rsp_ready            (rsp_ready),
      .rsp_result_kind      (rsp_result_kind),
      .rsp_channel          (rsp_channel),
      .rsp_sample_value     (rsp_sample_value),
      .rsp_sample_index     (rsp_sample_index),
      .rsp_last             (rsp_last),
      .rsp_round_complete   (rsp_round_complete),
      .rsp_acquisition_done (rsp_acquisition_done),
      .rsp_start_conversion (rsp_start_conversion)
   );

endmodule

// ----- hdl/msc_checker.sv -----
// ---------------------------------------------------------------------------
// Sample collector port checker
// Concurrent checks on the response channel, bound to the top level.
// ---------------------------------------------------------------------------
`include "multichannel_sample_collector_assert.svh"

module msc_checker (
   input logic       clock,
   input logic       reset,
   input logic       rsp_valid,
   input logic       rsp_ready,
   input logic [1:0] rsp_result_kind,
   input logic [1:0] rsp_channel,
   input logic       rsp_last,
   input logic       rsp_round_complete,
   input logic       rsp_acquisition_done,
   input logic       rsp_start_conversion
);

   `MSC_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid, "response dropped while stalled")

   `MSC_ASSERT_IMPL(a_start_single, clock, reset, rsp_valid && (rsp_result_kind == msc_pkg::KIND_START), rsp_last && (rsp_channel == 2'd0) && !rsp_round_complete, "start response malformed")

   `MSC_ASSERT_IMPL(a_flags_on_last, clock, reset, rsp_valid && !rsp_last, !rsp_round_complete && !rsp_acquisition_done && !rsp_start_conversion, "end flags on a non-last response")

   `MSC_ASSERT_IMPL(a_done_round, clock, reset, rsp_valid && rsp_acquisition_done, rsp_round_complete && !rsp_start_conversion, "done without round completion")

endmodule

bind multichannel_sample_collector msc_checker u_msc_checker (.*);
